[hdl/sprite_frame_animator_defines.svh]
// ----------------------------------------------------------------------------
// sprite_frame_animator_defines
// assertion macros shared by the animator modules
// ----------------------------------------------------------------------------
`ifndef SPRITE_FRAME_ANIMATOR_DEFINES_SVH
`define SPRITE_FRAME_ANIMATOR_DEFINES_SVH

// same-cycle implication, clocked on clk, off while rst_n is low
`define SFA_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on clk, off while rst_n is low
`define SFA_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/sfa_pkg.sv]
// ----------------------------------------------------------------------------
// sfa_pkg
// shared constants, register map and sequencer states of the animator
// ----------------------------------------------------------------------------
package sfa_pkg;

    localparam int FRAME_BITS_DEF = 12;
    localparam int TIME_BITS_DEF  = 24;

    // timer is unsigned q16.16
    localparam int ACCUM_BITS = 32;

    localparam int COL_W    = 8;
    localparam int SIZE_W   = 10;
    localparam int RECT_X_W = 18;
    localparam int RECT_Y_W = 22;

    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 5;

    localparam logic [31:0]       DELAY_RESET   = 32'd65536;
    localparam logic              LOOP_RESET    = 1'b1;
    localparam logic [COL_W-1:0]  COLUMNS_RESET = 8'd1;
    localparam logic [SIZE_W-1:0] SIZE_RESET    = 10'd2;

    localparam logic OP_TICK      = 1'b0;
    localparam logic OP_SET_FRAME = 1'b1;

    typedef enum logic [2:0] {
        REG_START_FRAME,
        REG_END_FRAME,
        REG_FRAME_DELAY,
        REG_LOOP_ENABLE,
        REG_COLUMNS,
        REG_FRAME_WIDTH,
        REG_FRAME_HEIGHT
    } sfa_reg_e;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TIMER,
        ST_STEP,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_MUL,
        ST_OUT
    } sfa_state_e;

endpackage

[hdl/sfa_in_if.sv]
// ----------------------------------------------------------------------------
// sfa_in_if
// request channel of the animator: tick or set-frame
// ----------------------------------------------------------------------------
interface sfa_in_if #(
    parameter int FRAME_BITS = sfa_pkg::FRAME_BITS_DEF,
    parameter int TIME_BITS  = sfa_pkg::TIME_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic                  opcode;
    logic [TIME_BITS-1:0]  elapsed;
    logic [FRAME_BITS-1:0] new_frame;

    modport source (output valid, output opcode, output elapsed, output new_frame,
                    input ready);
    modport sink   (input valid, input opcode, input elapsed, input new_frame,
                    output ready);
endinterface

[hdl/sfa_out_if.sv]
// ----------------------------------------------------------------------------
// sfa_out_if
// result channel of the animator: frame index and sheet rectangle
// ----------------------------------------------------------------------------
interface sfa_out_if #(
    parameter int FRAME_BITS = sfa_pkg::FRAME_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic [FRAME_BITS-1:0]         frame_index;
    logic [sfa_pkg::RECT_X_W-1:0]  rect_left;
    logic [sfa_pkg::RECT_X_W-1:0]  rect_right;
    logic [sfa_pkg::RECT_Y_W-1:0]  rect_top;
    logic [sfa_pkg::RECT_Y_W-1:0]  rect_bottom;
    logic                          anim_done;

    modport source (output valid, output frame_index, output rect_left,
                    output rect_right, output rect_top, output rect_bottom,
                    output anim_done, input ready);
    modport sink   (input valid, input frame_index, input rect_left,
                    input rect_right, input rect_top, input rect_bottom,
                    input anim_done, output ready);
endinterface

[hdl/sprite_frame_animator.sv]
// ----------------------------------------------------------------------------
// sprite_frame_animator
// sprite-sheet animation sequencer with apb settings and a serial divider
// ----------------------------------------------------------------------------
// usage
//   in_req carries one request per handshake: a tick (opcode 0) adds elapsed
//   q8.16 seconds to the frame timer, a set-frame (opcode 1) loads new_frame
//   and clears anim_done. every request gives exactly one result on out_rsp:
//   the current frame and its rectangle in the sheet.
//   settings are written through the apb port, one 32-bit register every
//   4 bytes. the user must write them only while no request is in flight;
//   the block itself does not enforce this. pready is always high.
// sequencing
//   the serial divider splits the frame into row and column, one quotient
//   bit per cycle. a new request is taken the cycle after the result is
//   loaded into the output register, not while one is being worked on.
// reset
//   rst_n clears frame, timer, done flag and the sequencer; the settings
//   return to their defaults (one-second delay, looping, one column, 2x2).
// stall
//   the result sits in an output register; the next request is accepted and
//   worked on, and only waits in its last step until that register is free.
// ----------------------------------------------------------------------------
`include "sprite_frame_animator_defines.svh"

module sprite_frame_animator #(
    parameter int FRAME_BITS = sfa_pkg::FRAME_BITS_DEF,
    parameter int TIME_BITS  = sfa_pkg::TIME_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    sfa_in_if.sink                         in_req,
    sfa_out_if.source                      out_rsp,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [sfa_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [sfa_pkg::APB_DATA_W-1:0] pwdata,
    output logic [sfa_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);

    localparam int ACC_W = sfa_pkg::ACCUM_BITS;
    localparam int TOP_W = FRAME_BITS + sfa_pkg::SIZE_W;
    localparam int XW    = sfa_pkg::RECT_X_W;
    localparam int YW    = sfa_pkg::RECT_Y_W;

    // settings
    logic [FRAME_BITS-1:0]      start_frame;
    logic [FRAME_BITS-1:0]      end_frame;
    logic [TIME_BITS-1:0]       frame_delay;
    logic                       loop_enable;
    logic [sfa_pkg::COL_W-1:0]  columns;
    logic [sfa_pkg::SIZE_W-1:0] frame_width;
    logic [sfa_pkg::SIZE_W-1:0] frame_height;
    logic [sfa_pkg::COL_W-1:0]  cols_eff;

    // sequencer and animation state
    sfa_pkg::sfa_state_e    state_reg, state_next;
    logic [FRAME_BITS-1:0]  frame_reg, frame_next;
    logic [ACC_W-1:0]       accum_reg, accum_next;
    logic                   done_reg,  done_next;
    logic [TIME_BITS-1:0]   elapsed_reg, elapsed_next;

    // rectangle products
    logic [XW-1:0]          left_reg, left_next;
    logic [YW-1:0]          top_reg,  top_next;
    logic [TOP_W-1:0]       top_prod;

    // output register
    logic                   out_valid_reg, out_valid_next;
    logic [FRAME_BITS-1:0]  out_frame_reg, out_frame_next;
    logic [XW-1:0]          out_left_reg,  out_left_next;
    logic [XW-1:0]          out_right_reg, out_right_next;
    logic [YW-1:0]          out_top_reg,   out_top_next;
    logic [YW-1:0]          out_bot_reg,   out_bot_next;
    logic                   out_done_reg,  out_done_next;

    // timer and step arithmetic
    logic [ACC_W:0]         acc_sum;
    logic [FRAME_BITS:0]    frame_inc;
    logic                   range_ok;
    logic                   step_due;

    // divider hookup
    logic                       div_start;
    logic [FRAME_BITS-1:0]      div_quot;
    logic [sfa_pkg::COL_W-1:0]  div_rem;
    logic                       div_done;

    sfa_cfg #(
        .FRAME_BITS (FRAME_BITS),
        .TIME_BITS  (TIME_BITS)
    ) u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .start_frame  (start_frame),
        .end_frame    (end_frame),
        .frame_delay  (frame_delay),
        .loop_enable  (loop_enable),
        .columns      (columns),
        .frame_width  (frame_width),
        .frame_height (frame_height)
    );

    sfa_div #(
        .FRAME_BITS (FRAME_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (frame_reg),
        .divisor   (cols_eff),
        .quotient  (div_quot),
        .remainder (div_rem),
        .done      (div_done)
    );

    assign pready   = 1'b1;
    // zero columns behaves as a single column
    assign cols_eff = (columns == '0) ? sfa_pkg::COL_W'(1) : columns;

    // timer only runs when the range holds more than one frame
    assign range_ok  = (end_frame > start_frame);
    assign acc_sum   = {1'b0, accum_reg} + (ACC_W + 1)'(elapsed_reg);
    assign step_due  = (accum_reg > ACC_W'(frame_delay));
    assign frame_inc = {1'b0, frame_reg} + (FRAME_BITS + 1)'(1);
    assign top_prod  = TOP_W'(div_quot) * TOP_W'(frame_height);

    assign in_req.ready = (state_reg == sfa_pkg::ST_IDLE);
    assign div_start    = (state_reg == sfa_pkg::ST_DIV_START);

    always_comb
    begin
        state_next     = state_reg;
        frame_next     = frame_reg;
        accum_next     = accum_reg;
        done_next      = done_reg;
        elapsed_next   = elapsed_reg;
        left_next      = left_reg;
        top_next       = top_reg;
        out_valid_next = out_valid_reg;
        out_frame_next = out_frame_reg;
        out_left_next  = out_left_reg;
        out_right_next = out_right_reg;
        out_top_next   = out_top_reg;
        out_bot_next   = out_bot_reg;
        out_done_next  = out_done_reg;

        // consumer drains the held result
        if (out_valid_reg && out_rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            sfa_pkg::ST_IDLE:
            begin
                if (in_req.valid)
                begin
                    if (in_req.opcode == sfa_pkg::OP_SET_FRAME)
                    begin
                        // timer is kept on a set-frame
                        frame_next = in_req.new_frame;
                        done_next  = 1'b0;
                        state_next = sfa_pkg::ST_DIV_START;
                    end
                    else
                    begin
                        elapsed_next = in_req.elapsed;
                        state_next   = sfa_pkg::ST_TIMER;
                    end
                end
            end
            sfa_pkg::ST_TIMER:
            begin
                if (range_ok)
                begin
                    // saturate instead of wrapping
                    accum_next = acc_sum[ACC_W] ? '1 : acc_sum[ACC_W-1:0];
                    state_next = sfa_pkg::ST_STEP;
                end
                else
                begin
                    state_next = sfa_pkg::ST_DIV_START;
                end
            end
            sfa_pkg::ST_STEP:
            begin
                // at most one frame advance per tick
                if (step_due)
                begin
                    accum_next = accum_reg - ACC_W'(frame_delay);
                    if ((frame_inc < (FRAME_BITS + 1)'(start_frame)) ||
                        (frame_inc > (FRAME_BITS + 1)'(end_frame)))
                    begin
                        if (loop_enable)
                        begin
                            frame_next = start_frame;
                        end
                        else
                        begin
                            frame_next = end_frame;
                            done_next  = 1'b1;
                        end
                    end
                    else
                    begin
                        frame_next = frame_inc[FRAME_BITS-1:0];
                    end
                end
                state_next = sfa_pkg::ST_DIV_START;
            end
            sfa_pkg::ST_DIV_START:
            begin
                state_next = sfa_pkg::ST_DIV_WAIT;
            end
            sfa_pkg::ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    state_next = sfa_pkg::ST_MUL;
                end
            end
            sfa_pkg::ST_MUL:
            begin
                // column and row scaled by the frame size
                left_next  = XW'(div_rem) * XW'(frame_width);
                top_next   = YW'(top_prod);
                state_next = sfa_pkg::ST_OUT;
            end
            sfa_pkg::ST_OUT:
            begin
                // wait for the output register to be free
                if (!out_valid_reg || out_rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_frame_next = frame_reg;
                    out_left_next  = left_reg;
                    out_right_next = left_reg + XW'(frame_width);
                    out_top_next   = top_reg;
                    out_bot_next   = top_reg + YW'(frame_height);
                    out_done_next  = done_reg;
                    state_next     = sfa_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sfa_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sfa_pkg::ST_IDLE;
            frame_reg     <= '0;
            accum_reg     <= '0;
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            frame_reg     <= frame_next;
            accum_reg     <= accum_next;
            done_reg      <= done_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        elapsed_reg   <= elapsed_next;
        left_reg      <= left_next;
        top_reg       <= top_next;
        out_frame_reg <= out_frame_next;
        out_left_reg  <= out_left_next;
        out_right_reg <= out_right_next;
        out_top_reg   <= out_top_next;
        out_bot_reg   <= out_bot_next;
        out_done_reg  <= out_done_next;
    end

    assign out_rsp.valid       = out_valid_reg;
    assign out_rsp.frame_index = out_frame_reg;
    assign out_rsp.rect_left   = out_left_reg;
    assign out_rsp.rect_right  = out_right_reg;
    assign out_rsp.rect_top    = out_top_reg;
    assign out_rsp.rect_bottom = out_bot_reg;
    assign out_rsp.anim_done   = out_done_reg;

    // a looping advance always lands inside the range
    `SFA_ASSERT_NEXT(a_step_in_range,
        (state_reg == sfa_pkg::ST_STEP) && step_due && loop_enable && range_ok,
        (frame_reg >= start_frame) && (frame_reg <= end_frame),
        "looping advance left the frame range")
    // completion only comes from a non-looping advance
    `SFA_ASSERT_NOW(a_done_source, $rose(done_reg),
        ($past(state_reg) == sfa_pkg::ST_STEP) && !loop_enable,
        "done flag set outside a non-looping step")
    // column handed to the multiply is below the column count
    `SFA_ASSERT_NOW(a_col_bound, state_reg == sfa_pkg::ST_MUL, div_rem < cols_eff,
        "column out of range")
    // a result only appears from the final step
    `SFA_ASSERT_NOW(a_out_source, $rose(out_valid_reg),
        $past(state_reg) == sfa_pkg::ST_OUT, "result shown outside the final step")

endmodule

[hdl/sfa_cfg.sv]
// ----------------------------------------------------------------------------
// sfa_cfg
// apb register file holding the animation settings
// ----------------------------------------------------------------------------
module sfa_cfg #(
    parameter int FRAME_BITS = sfa_pkg::FRAME_BITS_DEF,
    parameter int TIME_BITS  = sfa_pkg::TIME_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [sfa_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [sfa_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [sfa_pkg::APB_DATA_W-1:0]   prdata,
    output logic [FRAME_BITS-1:0]            start_frame,
    output logic [FRAME_BITS-1:0]            end_frame,
    output logic [TIME_BITS-1:0]             frame_delay,
    output logic                             loop_enable,
    output logic [sfa_pkg::COL_W-1:0]        columns,
    output logic [sfa_pkg::SIZE_W-1:0]       frame_width,
    output logic [sfa_pkg::SIZE_W-1:0]       frame_height
);

    logic [FRAME_BITS-1:0]       start_reg,  start_next;
    logic [FRAME_BITS-1:0]       end_reg,    end_next;
    logic [TIME_BITS-1:0]        delay_reg,  delay_next;
    logic                        loop_reg,   loop_next;
    logic [sfa_pkg::COL_W-1:0]   cols_reg,   cols_next;
    logic [sfa_pkg::SIZE_W-1:0]  width_reg,  width_next;
    logic [sfa_pkg::SIZE_W-1:0]  height_reg, height_next;

    sfa_pkg::sfa_reg_e reg_sel;
    logic              wr_en;

    assign reg_sel = sfa_pkg::sfa_reg_e'(paddr[sfa_pkg::APB_ADDR_W-1:2]);
    assign wr_en   = psel && penable && pwrite;

    always_comb
    begin
        start_next  = start_reg;
        end_next    = end_reg;
        delay_next  = delay_reg;
        loop_next   = loop_reg;
        cols_next   = cols_reg;
        width_next  = width_reg;
        height_next = height_reg;
        if (wr_en)
        begin
            case (reg_sel)
                sfa_pkg::REG_START_FRAME:  start_next  = pwdata[FRAME_BITS-1:0];
                sfa_pkg::REG_END_FRAME:    end_next    = pwdata[FRAME_BITS-1:0];
                sfa_pkg::REG_FRAME_DELAY:  delay_next  = pwdata[TIME_BITS-1:0];
                sfa_pkg::REG_LOOP_ENABLE:  loop_next   = pwdata[0];
                sfa_pkg::REG_COLUMNS:      cols_next   = pwdata[sfa_pkg::COL_W-1:0];
                sfa_pkg::REG_FRAME_WIDTH:  width_next  = pwdata[sfa_pkg::SIZE_W-1:0];
                sfa_pkg::REG_FRAME_HEIGHT: height_next = pwdata[sfa_pkg::SIZE_W-1:0];
                default:                   ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            sfa_pkg::REG_START_FRAME:  prdata = sfa_pkg::APB_DATA_W'(start_reg);
            sfa_pkg::REG_END_FRAME:    prdata = sfa_pkg::APB_DATA_W'(end_reg);
            sfa_pkg::REG_FRAME_DELAY:  prdata = sfa_pkg::APB_DATA_W'(delay_reg);
            sfa_pkg::REG_LOOP_ENABLE:  prdata = sfa_pkg::APB_DATA_W'(loop_reg);
            sfa_pkg::REG_COLUMNS:      prdata = sfa_pkg::APB_DATA_W'(cols_reg);
            sfa_pkg::REG_FRAME_WIDTH:  prdata = sfa_pkg::APB_DATA_W'(width_reg);
            sfa_pkg::REG_FRAME_HEIGHT: prdata = sfa_pkg::APB_DATA_W'(height_reg);
            default:                   prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg  <= '0;
            end_reg    <= '0;
            delay_reg  <= TIME_BITS'(sfa_pkg::DELAY_RESET);
            loop_reg   <= sfa_pkg::LOOP_RESET;
            cols_reg   <= sfa_pkg::COLUMNS_RESET;
            width_reg  <= sfa_pkg::SIZE_RESET;
            height_reg <= sfa_pkg::SIZE_RESET;
        end
        else
        begin
            start_reg  <= start_next;
            end_reg    <= end_next;
            delay_reg  <= delay_next;
            loop_reg   <= loop_next;
            cols_reg   <= cols_next;
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    assign start_frame  = start_reg;
    assign end_frame    = end_reg;
    assign frame_delay  = delay_reg;
    assign loop_enable  = loop_reg;
    assign columns      = cols_reg;
    assign frame_width  = width_reg;
    assign frame_height = height_reg;

endmodule

[hdl/sfa_div.sv]
// ----------------------------------------------------------------------------
// sfa_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`include "sprite_frame_animator_defines.svh"

module sfa_div #(
    parameter int FRAME_BITS = sfa_pkg::FRAME_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [FRAME_BITS-1:0]         dividend,
    input  logic [sfa_pkg::COL_W-1:0]     divisor,
    output logic [FRAME_BITS-1:0]         quotient,
    output logic [sfa_pkg::COL_W-1:0]     remainder,
    output logic                          done
);

    localparam int CNT_W = $clog2(FRAME_BITS + 1);

    logic [FRAME_BITS-1:0]     quot_reg, quot_next;
    logic [sfa_pkg::COL_W-1:0] rem_reg,  rem_next;
    logic [sfa_pkg::COL_W-1:0] dvsr_reg, dvsr_next;
    logic [CNT_W-1:0]          cnt_reg,  cnt_next;
    logic                      busy_reg, busy_next;
    logic                      done_reg, done_next;
    logic [sfa_pkg::COL_W:0]   shifted;
    logic [sfa_pkg::COL_W:0]   diff;
    logic                      fits;

    // partial remainder stays below the divisor, so one shift fits COL_W+1 bits
    assign shifted = {rem_reg, quot_reg[FRAME_BITS-1]};
    assign diff    = shifted - {1'b0, dvsr_reg};
    assign fits    = (shifted >= {1'b0, dvsr_reg});

    always_comb
    begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        dvsr_next = dvsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quot_next = dividend;
            rem_next  = '0;
            dvsr_next = divisor;
            cnt_next  = CNT_W'(FRAME_BITS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? diff[sfa_pkg::COL_W-1:0] : shifted[sfa_pkg::COL_W-1:0];
            quot_next = {quot_reg[FRAME_BITS-2:0], fits};
            cnt_next  = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dvsr_reg <= dvsr_next;
    end

    assign quotient  = quot_reg;
    assign remainder = rem_reg;
    assign done      = done_reg;

    `SFA_ASSERT_NOW(a_div_no_restart, start, !busy_reg, "divider restarted while busy")
    `SFA_ASSERT_NOW(a_div_rem_bound, busy_reg, rem_reg < dvsr_reg, "partial remainder too large")
    `SFA_ASSERT_NEXT(a_div_done_ends, done_reg, !done_reg, "divider done held over two cycles")

endmodule
